// ----- design/ssd_pkg.sv -----
package ssd_pkg;

    localparam int unsigned BitsPerBeat = 24;
    localparam int unsigned CntW = $clog2(BitsPerBeat + 1);

    localparam logic [1:0] FUNC_NUMBER = 2'd0;
    localparam logic [1:0] FUNC_HEX    = 2'd1;
    localparam logic [1:0] FUNC_BLINK  = 2'd2;
    localparam logic [1:0] FUNC_RAW    = 2'd3;

    localparam logic [1:0] BLINK_HUNDREDS = 2'd0;
    localparam logic [1:0] BLINK_TENS     = 2'd1;
    localparam logic [1:0] BLINK_UNITS    = 2'd2;

    localparam logic [4:0] CODE_HEX_MAX = 5'd15;
    localparam logic [4:0] CODE_BLANK   = 5'd16;
    localparam logic [9:0] NUMBER_MAX   = 10'd999;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] number;
        logic [7:0]  digit_hundreds;
        logic [7:0]  digit_tens;
        logic [7:0]  digit_units;
        logic [1:0]  blink_position;
        logic        blink_visible;
    } t_ssd_req;

    typedef struct packed {
        logic serial_data;
        logic last;
    } t_ssd_res;

    function automatic logic [7:0] seg_encode(input logic [4:0] code);
        logic [7:0] seg;
        unique case (code)
            5'd0:    seg = 8'hC0;
            5'd1:    seg = 8'hF9;
            5'd2:    seg = 8'hA4;
            5'd3:    seg = 8'hB0;
            5'd4:    seg = 8'h99;
            5'd5:    seg = 8'h92;
            5'd6:    seg = 8'h82;
            5'd7:    seg = 8'hF8;
            5'd8:    seg = 8'h80;
            5'd9:    seg = 8'h90;
            5'd10:   seg = 8'h88;
            5'd11:   seg = 8'h83;
            5'd12:   seg = 8'hC6;
            5'd13:   seg = 8'hA1;
            5'd14:   seg = 8'h86;
            5'd15:   seg = 8'h8E;
            5'd16:   seg = 8'hFF;
            5'd17:   seg = 8'h7F;
            default: seg = 8'hFF;
        endcase
        return seg;
    endfunction

    function automatic logic [4:0] clamp_code(input logic [7:0] v, input logic [4:0] top);
        logic [4:0] c;
        if (v > {3'd0, top}) begin
            c = top;
        end else begin
            c = v[4:0];
        end
        return c;
    endfunction

endpackage

// ----- design/ssd_encode.sv -----
module ssd_encode import ssd_pkg::*; (
    input  t_ssd_req                i_req,
    output logic [BitsPerBeat-1:0]  o_word
);

    logic [9:0]  num_sat;
    logic [15:0] hund_prod;
    logic [3:0]  dec_h;
    logic [6:0]  rem_h;
    logic [14:0] tens_prod;
    logic [3:0]  dec_t;
    logic [6:0]  dec_u_w;
    logic [4:0]  code_h;
    logic [4:0]  code_t;
    logic [4:0]  code_u;

    // Decimal split by reciprocal multiplication, exact for values up to 999.
    always_comb begin
        num_sat   = (i_req.number > {6'd0, NUMBER_MAX}) ? NUMBER_MAX : i_req.number[9:0];
        hund_prod = {6'd0, num_sat} * 16'd41;
        dec_h     = hund_prod[15:12];
        rem_h     = 7'(num_sat - 10'(dec_h) * 10'd100);
        tens_prod = {8'd0, rem_h} * 15'd205;
        dec_t     = tens_prod[14:11];
        dec_u_w   = rem_h - 7'(dec_t) * 7'd10;
    end

    always_comb begin
        code_h = 5'(dec_h);
        code_t = 5'(dec_t);
        code_u = dec_u_w[4:0];
        unique case (i_req.func)
            FUNC_NUMBER: begin
                code_h = 5'(dec_h);
                code_t = 5'(dec_t);
                code_u = dec_u_w[4:0];
            end
            FUNC_HEX: begin
                code_h = clamp_code(i_req.digit_hundreds, CODE_HEX_MAX);
                code_t = clamp_code(i_req.digit_tens, CODE_HEX_MAX);
                code_u = clamp_code(i_req.digit_units, CODE_HEX_MAX);
            end
            default: begin
                code_h = clamp_code(i_req.digit_hundreds, CODE_BLANK);
                code_t = clamp_code(i_req.digit_tens, CODE_BLANK);
                code_u = clamp_code(i_req.digit_units, CODE_BLANK);
                if (!i_req.blink_visible) begin
                    unique case (i_req.blink_position)
                        BLINK_HUNDREDS: begin
                            code_h = CODE_BLANK;
                        end
                        BLINK_TENS: begin
                            code_t = CODE_BLANK;
                        end
                        BLINK_UNITS: begin
                            code_u = CODE_BLANK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        endcase
    end

    always_comb begin
        if (i_req.func == FUNC_RAW) begin
            o_word = {i_req.digit_units, i_req.digit_tens, i_req.digit_hundreds};
        end else begin
            o_word = {seg_encode(code_u), seg_encode(code_t), seg_encode(code_h)};
        end
    end

endmodule

// ----- design/ssd_shifter.sv -----
module ssd_shifter import ssd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic [BitsPerBeat-1:0]  i_word,
    output logic                    o_can_load,
    output logic                    o_strobe,
    output t_ssd_res                o_res
);

    logic [BitsPerBeat-1:0] r_word;
    logic [BitsPerBeat-1:0] n_word;
    logic [CntW-1:0]        r_cnt;
    logic [CntW-1:0]        n_cnt;
    logic                   r_strobe;
    t_ssd_res               r_res;
    logic                   active;

    assign active     = (r_cnt != '0);
    assign o_can_load = (r_cnt <= CntW'(1));

    always_comb begin
        n_word = r_word;
        n_cnt  = r_cnt;
        if (i_load) begin
            n_word = i_word;
            n_cnt  = CntW'(BitsPerBeat);
        end else if (active) begin
            n_word = {r_word[BitsPerBeat-2:0], 1'b0};
            n_cnt  = r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_strobe <= active;
        end
        r_word            <= n_word;
        r_res.serial_data <= r_word[BitsPerBeat-1];
        r_res.last        <= (r_cnt == CntW'(1));
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

// ----- design/seven_segment_serial_driver_core.sv -----
// Channel   Handshake                 Payload
// request   i_start / o_busy          i_req (t_ssd_req)
// result    o_strobe                  o_res (t_ssd_res), one serial bit per beat
//
// A request beat gives 24 result beats on consecutive cycles; after the request
// is accepted into an idle block, the input valid register, the shifter count
// register and the strobe register lie before the first of them. A new request
// can be accepted while bits shift. The shifter emits one bit per cycle.
// A waiting request is held in the input register while bits are shifting.
// Reset is synchronous and active low and clears the control state only.
// The receiver cannot stall; results are never held back once started.
module seven_segment_serial_driver_core import ssd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_ssd_req i_req,
    output logic     o_busy,
    output logic     o_strobe,
    output t_ssd_res o_res
);

    t_ssd_req               r_in;
    logic                   r_in_valid;
    logic                   n_in_valid;
    logic                   accept;
    logic                   load;
    logic                   can_load;
    logic [BitsPerBeat-1:0] word;

    assign load   = r_in_valid && can_load;
    assign o_busy = r_in_valid && !can_load;
    assign accept = i_start && !o_busy;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (load) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        if (accept) begin
            r_in <= i_req;
        end
    end

    ssd_encode u_encode (
        .i_req  (r_in),
        .o_word (word)
    );

    ssd_shifter u_shifter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_word     (word),
        .o_can_load (can_load),
        .o_strobe   (o_strobe),
        .o_res      (o_res)
    );

    a_load_starts_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> ##2 o_strobe)
        else $error("Loaded word did not start a result burst.");

    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.last) |=> o_strobe)
        else $error("Result burst broke before its last bit.");

    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_in_valid)
        else $error("Accepted request was lost.");

endmodule

// ----- verif/ssd_bit_checker.sv -----
`timescale 1ns / 100ps
module ssd_bit_checker import ssd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  logic     i_busy,
    input  t_ssd_req i_req,
    input  logic     i_strobe,
    input  t_ssd_res i_res,
    output int       o_mismatches,
    output int       o_bits_due
);

    // Segment patterns for digit codes 0 to 17, code 0 in the low byte.
    localparam logic [18*8-1:0] DIGIT_FONT = {
        8'h7F, 8'hFF, 8'h8E, 8'h86, 8'hA1, 8'hC6, 8'h83, 8'h88, 8'h90,
        8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
    };

    t_ssd_res expected_bits [$];
    int       mismatches = 0;

    function automatic logic [7:0] glyph(input logic [4:0] code);
        return DIGIT_FONT[code*8 +: 8];
    endfunction

    function automatic logic [4:0] limit_code(input logic [7:0] v, input logic [4:0] top);
        return (v > {3'd0, top}) ? top : v[4:0];
    endfunction

    // Returns the three segment bytes in shift order: units, tens, hundreds.
    function automatic logic [23:0] segment_frame(input t_ssd_req r);
        logic [4:0]  hund;
        logic [4:0]  tens;
        logic [4:0]  units;
        int          value;
        logic [23:0] frame;
        hund  = '0;
        tens  = '0;
        units = '0;
        case (r.func)
            FUNC_NUMBER: begin
                value = (r.number > NUMBER_MAX) ? int'(NUMBER_MAX) : int'(r.number);
                units = 5'(value % 10);
                tens  = 5'((value / 10) % 10);
                hund  = 5'((value / 100) % 10);
            end
            FUNC_HEX: begin
                hund  = limit_code(r.digit_hundreds, CODE_HEX_MAX);
                tens  = limit_code(r.digit_tens, CODE_HEX_MAX);
                units = limit_code(r.digit_units, CODE_HEX_MAX);
            end
            FUNC_BLINK: begin
                hund  = limit_code(r.digit_hundreds, CODE_BLANK);
                tens  = limit_code(r.digit_tens, CODE_BLANK);
                units = limit_code(r.digit_units, CODE_BLANK);
                if (!r.blink_visible) begin
                    case (r.blink_position)
                        BLINK_HUNDREDS: hund  = CODE_BLANK;
                        BLINK_TENS:     tens  = CODE_BLANK;
                        BLINK_UNITS:    units = CODE_BLANK;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        if (r.func == FUNC_RAW) begin
            frame = {r.digit_units, r.digit_tens, r.digit_hundreds};
        end else begin
            frame = {glyph(units), glyph(tens), glyph(hund)};
        end
        return frame;
    endfunction

    always @(posedge i_clk) begin : watch
        logic [23:0] frame;
        t_ssd_res    want;
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                frame = segment_frame(i_req);
                for (int k = 23; k >= 0; k--) begin
                    expected_bits.push_back({frame[k], 1'(k == 0)});
                end
            end
            if (i_strobe !== 1'b0) begin
                if (expected_bits.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got data %b last %b",
                             $time, i_res.serial_data, i_res.last);
                    mismatches++;
                end else begin
                    want = expected_bits.pop_front();
                    if (i_res.serial_data !== want.serial_data) begin
                        $display("%0t: serial_data expected %b, got %b",
                                 $time, want.serial_data, i_res.serial_data);
                        mismatches++;
                    end
                    if (i_res.last !== want.last) begin
                        $display("%0t: last expected %b, got %b",
                                 $time, want.last, i_res.last);
                        mismatches++;
                    end
                end
            end
        end
        o_mismatches <= mismatches;
        o_bits_due   <= expected_bits.size();
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
module tb import ssd_pkg::*; ();

    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PER_PHASE = 65;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_start = 1'b0;
    t_ssd_req i_req   = '0;
    logic     o_busy;
    logic     o_strobe;
    t_ssd_res o_res;
    int       mismatches;
    int       bits_due;
    int       cycles = 0;

    always #5 i_clk = ~i_clk;

    seven_segment_serial_driver_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_req    (i_req),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    ssd_bit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_req        (i_req),
        .i_strobe     (o_strobe),
        .i_res        (o_res),
        .o_mismatches (mismatches),
        .o_bits_due   (bits_due)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_ssd_req make_req(input logic [1:0] mode, input logic [15:0] value,
                                          input logic [7:0] hund, input logic [7:0] tens,
                                          input logic [7:0] units, input logic [1:0] pos,
                                          input logic vis);
        t_ssd_req r;
        r.func           = mode;
        r.number         = value;
        r.digit_hundreds = hund;
        r.digit_tens     = tens;
        r.digit_units    = units;
        r.blink_position = pos;
        r.blink_visible  = vis;
        return r;
    endfunction

    // Mostly codes near the clamp limits, sometimes any byte.
    function automatic logic [7:0] rand_code();
        return ($urandom_range(9) < 7) ? 8'($urandom_range(17)) : 8'($urandom_range(255));
    endfunction

    function automatic t_ssd_req rand_req();
        t_ssd_req r;
        r = make_req(2'($urandom_range(3)), 16'($urandom_range(65535)), rand_code(),
                     rand_code(), rand_code(), 2'($urandom_range(3)), 1'($urandom_range(1)));
        case ($urandom_range(3))
            0, 1:    r.number = 16'($urandom_range(999));
            2:       r.number = 16'(990 + $urandom_range(20));
            default: ;
        endcase
        return r;
    endfunction

    task automatic send(input t_ssd_req r);
        i_start <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_busy !== 1'b0);
    endtask

    task automatic pause_sender(input int pct);
        int gap;
        gap = ($urandom_range(99) < pct) ? $urandom_range(1, 36) : 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) begin
                i_req <= rand_req();
                @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (bits_due != 0);
    endtask

    initial begin : stimulus
        t_ssd_req directed [$];
        int       pct;
        directed.push_back(make_req(FUNC_NUMBER, 16'd0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0));
        directed.push_back(make_req(FUNC_NUMBER, 16'd999, 8'hFF, 8'hFF, 8'hFF, 2'd3, 1'b1));
        directed.push_back(make_req(FUNC_NUMBER, 16'd1000, 8'h12, 8'h34, 8'h56, 2'd1, 1'b0));
        directed.push_back(make_req(FUNC_NUMBER, 16'hFFFF, 8'h00, 8'h00, 8'h00, 2'd2, 1'b0));
        directed.push_back(make_req(FUNC_NUMBER, 16'd507, 8'h09, 8'h10, 8'h11, 2'd0, 1'b1));
        directed.push_back(make_req(FUNC_HEX, 16'hFFFF, 8'd0, 8'd0, 8'd0, 2'd0, 1'b0));
        directed.push_back(make_req(FUNC_HEX, 16'd0, 8'd15, 8'd15, 8'd15, 2'd3, 1'b1));
        directed.push_back(make_req(FUNC_HEX, 16'd1234, 8'd16, 8'd255, 8'd10, 2'd1, 1'b0));
        directed.push_back(make_req(FUNC_HEX, 16'd42, 8'd9, 8'd12, 8'd128, 2'd2, 1'b0));
        directed.push_back(make_req(FUNC_BLINK, 16'd0, 8'd16, 8'd17, 8'd255, 2'd3, 1'b1));
        directed.push_back(make_req(FUNC_BLINK, 16'd0, 8'd1, 8'd2, 8'd3, 2'd0, 1'b0));
        directed.push_back(make_req(FUNC_BLINK, 16'd0, 8'd1, 8'd2, 8'd3, 2'd1, 1'b0));
        directed.push_back(make_req(FUNC_BLINK, 16'd0, 8'd1, 8'd2, 8'd3, 2'd2, 1'b0));
        directed.push_back(make_req(FUNC_BLINK, 16'd0, 8'd1, 8'd2, 8'd3, 2'd3, 1'b0));
        directed.push_back(make_req(FUNC_BLINK, 16'd0, 8'd4, 8'd5, 8'd6, 2'd0, 1'b1));
        directed.push_back(make_req(FUNC_BLINK, 16'hFFFF, 8'd255, 8'd16, 8'd8, 2'd2, 1'b0));
        directed.push_back(make_req(FUNC_BLINK, 16'd0, 8'd15, 8'd0, 8'd14, 2'd1, 1'b1));
        directed.push_back(make_req(FUNC_RAW, 16'd0, 8'h00, 8'h00, 8'h00, 2'd0, 1'b0));
        directed.push_back(make_req(FUNC_RAW, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 2'd3, 1'b1));
        directed.push_back(make_req(FUNC_RAW, 16'd1000, 8'hA5, 8'h3C, 8'h81, 2'd0, 1'b0));
        directed.push_back(make_req(FUNC_RAW, 16'd7, 8'h7F, 8'h10, 8'hFE, 2'd2, 1'b1));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            send(directed[i]);
        end
        drain();

        // Sender idling per phase: none, heavy, none, light.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1:       pct = 74;
                3:       pct = 31;
                default: pct = 0;
            endcase
            repeat (RANDOM_PER_PHASE) begin
                send(rand_req());
                pause_sender(pct);
            end
            drain();
        end

        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && bits_due == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
